// ===== rtl/plbe_pkg.sv =====
// shared types and codes for the parallel led bit-plane encoder
package plbe_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHANNEL_W = 3;
  localparam int LED_W = 9;
  localparam int COLOUR_W = 24;
  localparam int SAMPLE_W = 8;
  localparam int CFG_LEDS_W = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = 1;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [1:0] kind_t;

  localparam opcode_t OP_PIXEL = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_TICK = 2'd2;

  localparam kind_t KIND_PIXEL = 2'd0;
  localparam kind_t KIND_START = 2'd1;
  localparam kind_t KIND_TICK = 2'd2;

  localparam logic REG_LEDS_IN_USE = 1'b0;

  typedef struct packed {
    kind_t kind;
    logic [CHANNEL_W-1:0] channel;
    logic [LED_W-1:0] led;
    logic [COLOUR_W-1:0] colour;
  } item_t;

endpackage

// ===== rtl/plbe_front.sv =====
// front end: takes input words, drops the ones with no effect, classifies the rest
module plbe_front import plbe_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int MAX_LEDS = 512
) (
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [OPCODE_W-1:0]  opcode,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [LED_W-1:0]     led_index,
  input  logic [COLOUR_W-1:0]  colour,
  input  logic                 hold,
  input  logic                 q_space,
  output logic                 push,
  output item_t                push_item
);

  logic keep;

  always_comb begin
    push_item.kind = KIND_PIXEL;
    push_item.channel = channel;
    push_item.led = led_index;
    push_item.colour = colour;
    keep = 1'b0;
    unique case (opcode)
      OP_PIXEL: begin
        push_item.kind = KIND_PIXEL;
        keep = (int'(channel) < CHANNELS) && (int'(led_index) < MAX_LEDS);
      end
      OP_START: begin
        push_item.kind = KIND_START;
        keep = 1'b1;
      end
      OP_TICK: begin
        push_item.kind = KIND_TICK;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_ready = !hold && q_space;
  assign push = item_valid && item_ready && keep;

endmodule

// ===== rtl/plbe_queue.sv =====
// two-entry queue between front and back end
module plbe_queue import plbe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  space,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_AW:0] count;

  assign space = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_item = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/plbe_back.sv =====
// back end: plane memory per channel, frame sequencer and output register
module plbe_back import plbe_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int MAX_LEDS = 512,
  parameter int BITS_PER_LED = 24,
  parameter int LEAD_SAMPLES = 4,
  parameter int TRAIL_SAMPLES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CFG_LEDS_W-1:0] leds_in_use,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [SAMPLE_W-1:0]   sample,
  output logic                  frame_end
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int LW = (CW > CFG_LEDS_W) ? CW : CFG_LEDS_W;
  localparam int BW = (BITS_PER_LED > 1) ? $clog2(BITS_PER_LED) : 1;
  localparam int SEG_MAX = (LEAD_SAMPLES > TRAIL_SAMPLES) ? LEAD_SAMPLES : TRAIL_SAMPLES;
  localparam int SCW = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;

  localparam logic [1:0] SEG_IDLE = 2'd0;
  localparam logic [1:0] SEG_LEAD = 2'd1;
  localparam logic [1:0] SEG_BODY = 2'd2;
  localparam logic [1:0] SEG_TRAIL = 2'd3;

  localparam logic [1:0] PH_ONES = 2'd0;
  localparam logic [1:0] PH_PLANE = 2'd1;
  localparam logic [1:0] PH_ZERO = 2'd2;

  logic [1:0] seg;
  logic [SCW-1:0] seg_cnt;
  logic [1:0] phase;
  logic [BW-1:0] bit_idx;
  logic [AW-1:0] led_idx;
  logic [AW-1:0] clr_addr;

  logic [LW-1:0] cfg_ext;
  logic [CW-1:0] chain_leds;
  logic advance;
  logic take;
  logic do_tick;
  logic do_start;
  logic do_pixel;
  logic rd_en;
  logic [AW-1:0] wr_addr;
  logic [BITS_PER_LED-1:0] wr_word;
  logic [BITS_PER_LED-1:0] colour_word;

  logic lead_last;
  logic trail_last;
  logic body_last;
  logic tk_end;
  logic tk_ones;
  logic tk_plane;

  logic out_ones;
  logic out_plane;
  logic [BW-1:0] out_bit;
  logic [CHANNELS-1:0] plane_bits;
  logic [CHANNELS-1:0] sample_full;
  logic [CHANNELS+SAMPLE_W-1:0] sample_wide;

  // counts above the store size saturate
  assign cfg_ext = LW'(leds_in_use);
  assign chain_leds = (cfg_ext > LW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(cfg_ext);

  assign advance = !result_valid || result_ready;
  assign q_pop = q_valid && advance && !clearing;
  assign take = q_pop;
  assign do_tick = take && (q_item.kind == KIND_TICK);
  assign do_start = take && (q_item.kind == KIND_START);
  assign do_pixel = take && (q_item.kind == KIND_PIXEL);

  always_comb begin
    for (int i = 0; i < BITS_PER_LED; i++) begin
      colour_word[i] = (i < COLOUR_W) ? q_item.colour[i % COLOUR_W] : 1'b0;
    end
  end

  assign wr_addr = clearing ? clr_addr : AW'(q_item.led);
  assign wr_word = clearing ? '0 : colour_word;
  assign rd_en = do_tick && (seg == SEG_BODY) && (phase == PH_PLANE);

  generate
    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
      logic [BITS_PER_LED-1:0] mem [MAX_LEDS];
      logic [BITS_PER_LED-1:0] rd_word;
      logic wr_en;

      assign wr_en = clearing || (do_pixel && (int'(q_item.channel) == c));

      always_ff @(posedge clk) begin
        if (wr_en) begin
          mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
          rd_word <= mem[led_idx];
        end
      end

      assign plane_bits[c] = rd_word[out_bit];
    end
  endgenerate

  assign lead_last = seg_cnt == SCW'(LEAD_SAMPLES - 1);
  assign trail_last = seg_cnt == SCW'(TRAIL_SAMPLES - 1);
  assign body_last = (phase == PH_ZERO) && (bit_idx == BW'(BITS_PER_LED - 1)) &&
                     (CW'(led_idx) == chain_leds - CW'(1));

  always_comb begin
    tk_end = 1'b0;
    tk_ones = 1'b0;
    tk_plane = 1'b0;
    unique case (seg)
      SEG_LEAD: begin
        tk_end = lead_last && (chain_leds == '0) && (TRAIL_SAMPLES == 0);
      end
      SEG_BODY: begin
        tk_ones = phase == PH_ONES;
        tk_plane = phase == PH_PLANE;
        tk_end = body_last && (TRAIL_SAMPLES == 0);
      end
      SEG_TRAIL: begin
        tk_end = trail_last;
      end
      default: begin
        tk_end = 1'b0;
      end
    endcase
  end

  // clearing pass over every led row after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_LEDS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= SEG_IDLE;
      seg_cnt <= '0;
      phase <= PH_ONES;
      bit_idx <= '0;
      led_idx <= '0;
    end else if (do_start && (seg == SEG_IDLE)) begin
      seg_cnt <= '0;
      phase <= PH_ONES;
      bit_idx <= '0;
      led_idx <= '0;
      if (LEAD_SAMPLES > 0) begin
        seg <= SEG_LEAD;
      end else if (chain_leds != '0) begin
        seg <= SEG_BODY;
      end else if (TRAIL_SAMPLES > 0) begin
        seg <= SEG_TRAIL;
      end
    end else if (do_tick) begin
      unique case (seg)
        SEG_LEAD: begin
          seg_cnt <= seg_cnt + 1'b1;
          if (lead_last) begin
            seg_cnt <= '0;
            if (chain_leds != '0) begin
              seg <= SEG_BODY;
            end else if (TRAIL_SAMPLES > 0) begin
              seg <= SEG_TRAIL;
            end else begin
              seg <= SEG_IDLE;
            end
          end
        end
        SEG_BODY: begin
          if (phase != PH_ZERO) begin
            phase <= phase + 1'b1;
          end else begin
            phase <= PH_ONES;
            if (bit_idx != BW'(BITS_PER_LED - 1)) begin
              bit_idx <= bit_idx + 1'b1;
            end else begin
              bit_idx <= '0;
              led_idx <= led_idx + 1'b1;
            end
          end
          if (body_last) begin
            seg_cnt <= '0;
            led_idx <= '0;
            seg <= (TRAIL_SAMPLES > 0) ? SEG_TRAIL : SEG_IDLE;
          end
        end
        SEG_TRAIL: begin
          seg_cnt <= seg_cnt + 1'b1;
          if (trail_last) begin
            seg_cnt <= '0;
            seg <= SEG_IDLE;
          end
        end
        default: begin
          seg <= SEG_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= do_tick && (seg != SEG_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && do_tick) begin
      out_ones <= tk_ones;
      out_plane <= tk_plane;
      out_bit <= bit_idx;
      frame_end <= tk_end;
    end
  end

  assign sample_full = out_ones ? '1 : (out_plane ? plane_bits : '0);
  assign sample_wide = {{SAMPLE_W{1'b0}}, sample_full};
  assign sample = sample_wide[SAMPLE_W-1:0];

endmodule

// ===== rtl/parallel_led_bitplane_encoder_unit.sv =====
// top level: register port, front end, queue and back end of the bit-plane encoder
//
//   port group      direction  handshake             contents
//   item_*          in         item_valid/ready      opcode, channel, led_index, colour
//   result_*        out        result_valid/ready    sample, frame_end
//   apb             in/out     psel/penable, pready  leds_in_use at byte address 0
//
// one word per cycle while item_ready is high: a tick costs one sequencer step and, in its
// plane phase, one plane memory read; a set-pixel one whole led row write on its channel
// a result is valid the cycle after its tick is taken and is held until taken
// after reset a clearing pass writes MAX_LEDS rows, item_ready low
// a stalled result stops the back end; the two-word queue then fills and item_ready drops
module parallel_led_bitplane_encoder_unit import plbe_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int MAX_LEDS = 512,
  parameter int BITS_PER_LED = 24,
  parameter int LEAD_SAMPLES = 4,
  parameter int TRAIL_SAMPLES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [OPCODE_W-1:0]  opcode,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [LED_W-1:0]     led_index,
  input  logic [COLOUR_W-1:0]  colour,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [SAMPLE_W-1:0]  sample,
  output logic                 frame_end,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [CFG_LEDS_W-1:0] leds_in_use;
  logic clearing;
  logic q_space;
  logic push;
  item_t push_item;
  logic q_valid;
  logic q_pop;
  item_t q_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leds_in_use <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LEDS_IN_USE)) begin
      leds_in_use <= pwdata[CFG_LEDS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LEDS_IN_USE) ? {{(32 - CFG_LEDS_W){1'b0}}, leds_in_use}
                                                : '0;

  plbe_front #(
    .CHANNELS (CHANNELS),
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .channel    (channel),
    .led_index  (led_index),
    .colour     (colour),
    .hold       (clearing),
    .q_space    (q_space),
    .push       (push),
    .push_item  (push_item)
  );

  plbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .space     (q_space),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  plbe_back #(
    .CHANNELS      (CHANNELS),
    .MAX_LEDS      (MAX_LEDS),
    .BITS_PER_LED  (BITS_PER_LED),
    .LEAD_SAMPLES  (LEAD_SAMPLES),
    .TRAIL_SAMPLES (TRAIL_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .leds_in_use  (leds_in_use),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample       (sample),
    .frame_end    (frame_end)
  );

endmodule
